FILE: sv/dcrs_pkg.sv
package dcrs_pkg;

	localparam int VOLT_WIDTH  = 24;
	localparam int TIME_WIDTH  = 32;
	localparam int PHASE_WIDTH = 32;

	localparam int FRAC_WIDTH  = 32;
	localparam int SIN_STAGES  = 7;
	localparam int LATENCY     = 35;

	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [30:0] Q30_ONE      = 31'h4000_0000;

	localparam logic [31:0] SIN_C1 = 32'd1686629713;
	localparam logic [31:0] SIN_C3 = 32'd693598669;
	localparam logic [31:0] SIN_C5 = 32'd85569306;
	localparam logic [31:0] SIN_C7 = 32'd5026995;
	localparam logic [31:0] SIN_C9 = 32'd172272;

	typedef enum logic [1:0] {
		MODE_TRAN   = 2'd0,
		MODE_DCOP   = 2'd1,
		MODE_PHASOR = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		REG_DC_LEVEL     = 3'd0,
		REG_AC_AMPLITUDE = 3'd1,
		REG_PHASE_STEP   = 3'd2,
		REG_PHASE_OFFSET = 3'd3,
		REG_AC_DELAY     = 3'd4,
		REG_DC_RISE_TIME = 3'd5,
		REG_AC_RAMP_TIME = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic       valid;
		logic [1:0] mode;
		logic       lt_rise;
		logic       gt_delay;
		logic       lt_ramp;
		logic       fa_zero;
		logic       freq_match;
	} ctl_t;

endpackage

FILE: sv/dcrs_div.sv
module dcrs_div #(
	parameter int TW = dcrs_pkg::TIME_WIDTH
) (
	input  logic                            clk,
	input  logic [TW-1:0]                   num,
	input  logic [TW-1:0]                   den,
	output logic [dcrs_pkg::FRAC_WIDTH-1:0] quo
);

	localparam int N = dcrs_pkg::FRAC_WIDTH;

	logic [TW-1:0] rem_s [0:N-1];
	logic [TW-1:0] den_s [0:N-1];
	logic [N-1:0]  q_s   [0:N-1];

	// one quotient bit per stage
	for (genvar k = 0; k < N; k++) begin : g_step
		logic [TW-1:0] rem_in;
		logic [TW-1:0] den_in;
		logic [N-1:0]  q_in;
		logic [TW:0]   sh;
		logic [TW:0]   diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign q_in   = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign q_in   = q_s[k-1];
		end

		assign sh   = {rem_in, 1'b0};
		assign diff = sh - {1'b0, den_in};
		assign ge   = sh >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? diff[TW-1:0] : sh[TW-1:0];
			den_s[k] <= den_in;
			q_s[k]   <= {q_in[N-2:0], ge};
		end
	end

	assign quo = q_s[N-1];

endmodule

FILE: sv/dcrs_sin.sv
module dcrs_sin (
	input  logic        clk,
	input  logic [31:0] angle,
	output logic [30:0] mag,
	output logic        neg
);

	logic [30:0] u_s1, u_s2, u_s3, u_s4, u_s5, u_s6;
	logic        neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6;
	logic [30:0] u2_s2, u2_s3, u2_s4, u2_s5;
	logic [31:0] p_s3, p_s4, p_s5, p_s6;

	logic [61:0] uu;
	logic [62:0] m3, m4, m5, m6, m7;
	logic [30:0] u_fold;

	// fold odd quadrants onto the rising quarter
	assign u_fold = angle[30] ? (dcrs_pkg::Q30_ONE - {1'b0, angle[29:0]}) : {1'b0, angle[29:0]};

	assign uu = u_s1 * u_s1;
	assign m3 = u2_s2 * dcrs_pkg::SIN_C9;
	assign m4 = u2_s3 * p_s3;
	assign m5 = u2_s4 * p_s4;
	assign m6 = u2_s5 * p_s5;
	assign m7 = u_s6 * p_s6;

	always_ff @(posedge clk) begin
		u_s1   <= u_fold;
		neg_s1 <= angle[31];

		u2_s2  <= uu[60:30];
		u_s2   <= u_s1;
		neg_s2 <= neg_s1;

		p_s3   <= dcrs_pkg::SIN_C7 - m3[61:30];
		u2_s3  <= u2_s2;
		u_s3   <= u_s2;
		neg_s3 <= neg_s2;

		p_s4   <= dcrs_pkg::SIN_C5 - m4[61:30];
		u2_s4  <= u2_s3;
		u_s4   <= u_s3;
		neg_s4 <= neg_s3;

		p_s5   <= dcrs_pkg::SIN_C3 - m5[61:30];
		u2_s5  <= u2_s4;
		u_s5   <= u_s4;
		neg_s5 <= neg_s4;

		p_s6   <= dcrs_pkg::SIN_C1 - m6[61:30];
		u_s6   <= u_s5;
		neg_s6 <= neg_s5;

		if (m7[62:30] > {2'b00, dcrs_pkg::Q30_ONE}) begin
			mag <= dcrs_pkg::Q30_ONE;
			neg <= neg_s6;
		end else begin
			mag <= m7[60:30];
			neg <= neg_s6 && (m7[62:30] != '0);
		end
	end

endmodule

FILE: sv/dc_ramp_sine_source_eval.sv
// an accepted start reaches its done strobe through valid_s1, the ctl_s stages and done_sl
// throughput: one item per cycle, busy stays low
// depth is set by the 32-stage ramp fraction dividers
// reset: all seven registers read zero, pipeline empties, done low
// results are shown for one cycle and the receiver cannot stall
module dc_ramp_sine_source_eval #(
	parameter int VOLT_WIDTH  = dcrs_pkg::VOLT_WIDTH,
	parameter int TIME_WIDTH  = dcrs_pkg::TIME_WIDTH,
	parameter int PHASE_WIDTH = dcrs_pkg::PHASE_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    mode,
	input  logic [TIME_WIDTH-1:0]         time_tick,
	input  logic [PHASE_WIDTH-1:0]        analysis_step,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_idx,
	input  logic [(((VOLT_WIDTH > TIME_WIDTH) ? VOLT_WIDTH : TIME_WIDTH) > PHASE_WIDTH ?
		((VOLT_WIDTH > TIME_WIDTH) ? VOLT_WIDTH : TIME_WIDTH) : PHASE_WIDTH)-1:0] cfg_data,
	output logic                          done,
	output logic signed [VOLT_WIDTH-1:0]  voltage_re,
	output logic signed [VOLT_WIDTH-1:0]  voltage_im
);

	localparam int VW = VOLT_WIDTH;
	localparam int TW = TIME_WIDTH;
	localparam int PW = PHASE_WIDTH;
	localparam int FW = dcrs_pkg::FRAC_WIDTH;
	localparam int DW = (TW > PW) ? TW : PW;
	localparam int S_CIN = 4 + dcrs_pkg::SIN_STAGES;
	localparam int S_C = S_CIN + 1;
	localparam int S_DIV = 1 + FW;
	localparam int S_MIX = S_DIV + 1;
	localparam int S_LAST = S_MIX + 1;

	function automatic logic [VW-1:0] round_q30(input logic [VW-1:0] a, input logic [30:0] m);
		logic [VW+30:0] p;
		p = (VW+31)'(a) * (VW+31)'(m);
		p = p + (VW+31)'(2**29);
		return p[VW+29:30];
	endfunction

	function automatic logic [VW-1:0] round_frac(input logic [VW-1:0] a, input logic [FW-1:0] f);
		logic [VW+FW-1:0] p;
		p = (VW+FW)'(a) * (VW+FW)'(f);
		p = p + ((VW+FW)'(1) << (FW-1));
		return p[VW+FW-1:FW];
	endfunction

	function automatic logic signed [VW:0] with_sign(input logic n, input logic [VW-1:0] m);
		logic signed [VW:0] e;
		e = signed'({1'b0, m});
		return n ? -e : e;
	endfunction

	function automatic logic [VW-1:0] magn(input logic signed [VW:0] v);
		logic signed [VW:0] a;
		a = v[VW] ? -v : v;
		return a[VW-1:0];
	endfunction

	function automatic logic [VW-1:0] sat(input logic signed [VW+1:0] v);
		if (v[VW+1:VW-1] == '0 || v[VW+1:VW-1] == '1) begin
			return v[VW-1:0];
		end
		return v[VW+1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
	endfunction

	logic signed [VW-1:0] dc_level_q, ac_amplitude_q;
	logic [PW-1:0]        phase_step_q, phase_offset_q;
	logic [TW-1:0]        ac_delay_q, dc_rise_time_q, ac_ramp_time_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_level_q     <= '0;
			ac_amplitude_q <= '0;
			phase_step_q   <= '0;
			phase_offset_q <= '0;
			ac_delay_q     <= '0;
			dc_rise_time_q <= '0;
			ac_ramp_time_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				dcrs_pkg::REG_DC_LEVEL:     dc_level_q     <= cfg_data[VW-1:0];
				dcrs_pkg::REG_AC_AMPLITUDE: ac_amplitude_q <= cfg_data[VW-1:0];
				dcrs_pkg::REG_PHASE_STEP:   phase_step_q   <= cfg_data[PW-1:0];
				dcrs_pkg::REG_PHASE_OFFSET: phase_offset_q <= cfg_data[PW-1:0];
				dcrs_pkg::REG_AC_DELAY:     ac_delay_q     <= cfg_data[TW-1:0];
				dcrs_pkg::REG_DC_RISE_TIME: dc_rise_time_q <= cfg_data[TW-1:0];
				dcrs_pkg::REG_AC_RAMP_TIME: ac_ramp_time_q <= cfg_data[TW-1:0];
				default: begin
				end
			endcase
		end
	end

	assign busy = 1'b0;

	logic             valid_s1;
	logic [1:0]       mode_s1;
	logic [TW-1:0]    t_s1;
	logic [PW-1:0]    fa_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		mode_s1 <= mode;
		t_s1    <= time_tick;
		fa_s1   <= analysis_step;
	end

	// item control travels alongside the data
	dcrs_pkg::ctl_t ctl_next;
	dcrs_pkg::ctl_t ctl_s [2:S_LAST-1];
	logic [TW-1:0]  diff;
	logic [DW-1:0]  diff_ext;

	assign diff     = t_s1 - ac_delay_q;
	assign diff_ext = DW'(diff);

	always_comb begin
		ctl_next.valid      = valid_s1;
		ctl_next.mode       = mode_s1;
		ctl_next.lt_rise    = (dc_rise_time_q != '0) && (t_s1 < dc_rise_time_q);
		ctl_next.gt_delay   = t_s1 > ac_delay_q;
		ctl_next.lt_ramp    = t_s1 < ac_ramp_time_q;
		ctl_next.fa_zero    = fa_s1 == '0;
		ctl_next.freq_match = (fa_s1 == phase_step_q) || (phase_step_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 2; k < S_LAST; k++) begin
				ctl_s[k] <= '0;
			end
		end else begin
			ctl_s[2] <= ctl_next;
			for (int k = 3; k < S_LAST; k++) begin
				ctl_s[k] <= ctl_s[k-1];
			end
		end
	end

	logic [PW-1:0] diff_s2, prod_s3, ph;
	logic [31:0]   ang_re_s4, ang_im_s4, turn_ph, turn_off;

	assign ph       = prod_s3 + phase_offset_q;
	assign turn_ph  = 32'(ph) << (32 - PW);
	assign turn_off = 32'(phase_offset_q) << (32 - PW);

	always_ff @(posedge clk) begin
		diff_s2 <= diff_ext[PW-1:0];
		prod_s3 <= phase_step_q * diff_s2;
		if (ctl_s[3].mode == dcrs_pkg::MODE_PHASOR) begin
			ang_re_s4 <= turn_off + dcrs_pkg::QUARTER_TURN;
		end else begin
			ang_re_s4 <= turn_ph + dcrs_pkg::QUARTER_TURN;
		end
		ang_im_s4 <= turn_off;
	end

	logic [30:0] mag_re_sc, mag_im_sc;
	logic        neg_re_sc, neg_im_sc;

	dcrs_sin u_sin_re (
		.clk   (clk),
		.angle (ang_re_s4),
		.mag   (mag_re_sc),
		.neg   (neg_re_sc)
	);

	dcrs_sin u_sin_im (
		.clk   (clk),
		.angle (ang_im_s4),
		.mag   (mag_im_sc),
		.neg   (neg_im_sc)
	);

	logic signed [VW:0] cre_s [S_C:S_LAST-1];
	logic signed [VW:0] cim_s [S_C:S_LAST-1];
	logic               amp_neg;
	logic [VW-1:0]      amp_mag;

	assign amp_neg = ac_amplitude_q[VW-1];
	assign amp_mag = magn(VW'(ac_amplitude_q) == '0 ? '0 : (VW+1)'(ac_amplitude_q));

	always_ff @(posedge clk) begin
		cre_s[S_C] <= with_sign(amp_neg ^ neg_re_sc, round_q30(amp_mag, mag_re_sc));
		cim_s[S_C] <= with_sign(amp_neg ^ neg_im_sc, round_q30(amp_mag, mag_im_sc));
		for (int k = S_C + 1; k < S_LAST; k++) begin
			cre_s[k] <= cre_s[k-1];
			cim_s[k] <= cim_s[k-1];
		end
	end

	logic [FW-1:0] f_rise_sd, f_ramp_sd;

	dcrs_div #(.TW(TW)) u_div_rise (
		.clk (clk),
		.num (t_s1),
		.den (dc_rise_time_q),
		.quo (f_rise_sd)
	);

	dcrs_div #(.TW(TW)) u_div_ramp (
		.clk (clk),
		.num (t_s1),
		.den (ac_ramp_time_q),
		.quo (f_ramp_sd)
	);

	logic signed [VW:0] dcterm_sm, cterm_sm, dc_ext, c_div;
	logic [VW-1:0]      dc_mag, c_mag;

	assign dc_ext = (VW+1)'(dc_level_q);
	assign dc_mag = magn(dc_ext);
	assign c_div  = cre_s[S_DIV];
	assign c_mag  = magn(c_div);

	always_ff @(posedge clk) begin
		if (ctl_s[S_DIV].lt_rise) begin
			dcterm_sm <= with_sign(dc_ext[VW], round_frac(dc_mag, f_rise_sd));
		end else begin
			dcterm_sm <= dc_ext;
		end
		if (!ctl_s[S_DIV].gt_delay) begin
			cterm_sm <= '0;
		end else if (ctl_s[S_DIV].lt_ramp) begin
			cterm_sm <= with_sign(c_div[VW], round_frac(c_mag, f_ramp_sd));
		end else begin
			cterm_sm <= c_div;
		end
	end

	logic signed [VW+1:0] sum;
	logic [VW-1:0]        re_next, im_next;
	dcrs_pkg::ctl_t       ctl_m;

	assign ctl_m = ctl_s[S_MIX];
	assign sum   = (VW+2)'(dcterm_sm) + (VW+2)'(cterm_sm);

	always_comb begin
		re_next = '0;
		im_next = '0;
		case (ctl_m.mode)
			dcrs_pkg::MODE_TRAN: begin
				re_next = sat(sum);
			end
			dcrs_pkg::MODE_DCOP: begin
				re_next = (dc_rise_time_q != '0) ? '0 : dc_level_q;
			end
			dcrs_pkg::MODE_PHASOR: begin
				if (ctl_m.fa_zero) begin
					re_next = dc_level_q;
				end else if (ctl_m.freq_match) begin
					re_next = sat((VW+2)'(cre_s[S_MIX]));
					im_next = sat((VW+2)'(cim_s[S_MIX]));
				end
			end
			default: begin
			end
		endcase
	end

	logic          done_sl;
	logic [VW-1:0] re_sl, im_sl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_sl <= 1'b0;
		end else begin
			done_sl <= ctl_m.valid;
		end
	end

	always_ff @(posedge clk) begin
		re_sl <= re_next;
		im_sl <= im_next;
	end

	assign done       = done_sl;
	assign voltage_re = re_sl;
	assign voltage_im = im_sl;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##(dcrs_pkg::LATENCY) done)
		else $error("item lost in pipeline");

	a_no_ghost: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, dcrs_pkg::LATENCY))
		else $error("result without item");

	a_im_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_m.valid && ctl_m.mode != dcrs_pkg::MODE_PHASOR |=> voltage_im == '0)
		else $error("imaginary part outside phasor mode");

endmodule

FILE: dv/dc_ramp_sine_source_eval_tb.sv
module dc_ramp_sine_source_eval_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam longint VMAX = 64'sd8388607;
	localparam longint VMIN = -64'sd8388608;
	localparam logic [63:0] SINE_ONE = 64'd1 << 30;

	typedef struct {
		longint re;
		longint im;
	} volt_pair_t;

	typedef struct {
		logic [1:0]  mode;
		logic [31:0] t;
		logic [31:0] fa;
		bit          typed;
		longint      re;
		longint      im;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] mode;
	logic [dcrs_pkg::TIME_WIDTH-1:0] time_tick;
	logic [dcrs_pkg::PHASE_WIDTH-1:0] analysis_step;
	logic cfg_we;
	logic [2:0] cfg_idx;
	logic [31:0] cfg_data;
	logic done;
	logic signed [dcrs_pkg::VOLT_WIDTH-1:0] voltage_re;
	logic signed [dcrs_pkg::VOLT_WIDTH-1:0] voltage_im;

	dc_ramp_sine_source_eval dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.time_tick(time_tick), .analysis_step(analysis_step), .cfg_we(cfg_we),
		.cfg_idx(cfg_idx), .cfg_data(cfg_data), .done(done),
		.voltage_re(voltage_re), .voltage_im(voltage_im)
	);

	// shadow of the source settings
	logic [23:0] sh_dc, sh_amp;
	logic [31:0] sh_step, sh_offset, sh_delay, sh_rise, sh_ramp;

	volt_pair_t pending_volts[$];
	int errors = 0;

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	initial begin
		#2ms;
		$display("dc_ramp_sine_source_eval_tb NOT OK");
		$finish;
	end

	function automatic logic [63:0] abs_of(longint v);
		return (v < 0) ? 64'(-v) : 64'(v);
	endfunction

	function automatic longint scale_round(longint v, logic [63:0] m, int sh);
		logic [63:0] p, r;
		p = abs_of(v) * m;
		r = (p + (64'd1 << (sh - 1))) >> sh;
		return (v < 0) ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint soft_scale(longint v, logic [31:0] t, logic [31:0] len);
		logic [63:0] f;
		f = ({32'd0, t} << 32) / {32'd0, len};
		return scale_round(v, f, 32);
	endfunction

	function automatic longint sine_q30(logic [31:0] a);
		logic [63:0] u, u2, p, s;
		u = {34'd0, a[29:0]};
		if (a[30])
			u = SINE_ONE - u;
		u2 = (u * u) >> 30;
		p = 64'(dcrs_pkg::SIN_C9);
		p = 64'(dcrs_pkg::SIN_C7) - ((u2 * p) >> 30);
		p = 64'(dcrs_pkg::SIN_C5) - ((u2 * p) >> 30);
		p = 64'(dcrs_pkg::SIN_C3) - ((u2 * p) >> 30);
		p = 64'(dcrs_pkg::SIN_C1) - ((u2 * p) >> 30);
		s = (u * p) >> 30;
		if (s > SINE_ONE)
			s = SINE_ONE;
		return a[31] ? -longint'(s) : longint'(s);
	endfunction

	function automatic longint amp_times(longint amp, longint trig);
		longint c;
		c = scale_round(amp, abs_of(trig), 30);
		return (trig < 0) ? -c : c;
	endfunction

	function automatic longint clip_volt(longint v);
		return (v > VMAX) ? VMAX : (v < VMIN) ? VMIN : v;
	endfunction

	function automatic volt_pair_t source_volts(logic [1:0] md, logic [31:0] t,
			logic [31:0] fa);
		volt_pair_t o;
		longint dc, amp, e, c;
		logic [31:0] ph;
		dc = longint'(signed'(sh_dc));
		amp = longint'(signed'(sh_amp));
		o.re = 0;
		o.im = 0;
		case (md)
			dcrs_pkg::MODE_TRAN: begin
				e = dc;
				if (sh_rise != 0 && t < sh_rise)
					e = soft_scale(dc, t, sh_rise);
				if (t > sh_delay) begin
					ph = sh_step * (t - sh_delay) + sh_offset;
					c = amp_times(amp, sine_q30(ph + dcrs_pkg::QUARTER_TURN));
					if (t < sh_ramp)
						c = soft_scale(c, t, sh_ramp);
					e += c;
				end
				o.re = clip_volt(e);
			end
			dcrs_pkg::MODE_DCOP: o.re = (sh_rise != 0) ? 0 : dc;
			dcrs_pkg::MODE_PHASOR: begin
				if (fa == 0) begin
					o.re = dc;
				end else if (fa == sh_step || sh_step == 0) begin
					o.re = clip_volt(amp_times(amp,
						sine_q30(sh_offset + dcrs_pkg::QUARTER_TURN)));
					o.im = clip_volt(amp_times(amp, sine_q30(sh_offset)));
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	// result checker
	always @(posedge clk) begin
		volt_pair_t exp_v;
		if (arst_n && done) begin
			if (pending_volts.size() == 0) begin
				$display("%0t: unexpected item re=%0d im=%0d", $realtime, voltage_re,
					voltage_im);
				errors++;
			end else begin
				exp_v = pending_volts.pop_front();
				if (longint'(voltage_re) != exp_v.re) begin
					$display("%0t: voltage_re expected %0d got %0d", $realtime, exp_v.re,
						voltage_re);
					errors++;
				end
				if (longint'(voltage_im) != exp_v.im) begin
					$display("%0t: voltage_im expected %0d got %0d", $realtime, exp_v.im,
						voltage_im);
					errors++;
				end
			end
		end
	end

	task automatic send_item(logic [1:0] md, logic [31:0] t, logic [31:0] fa,
			bit typed = 0, longint re = 0, longint im = 0);
		volt_pair_t v;
		@(negedge clk);
		start <= 1'b1;
		mode <= md;
		time_tick <= t;
		analysis_step <= fa;
		do @(posedge clk); while (busy);
		v = source_volts(md, t, fa);
		if (typed) begin
			v.re = re;
			v.im = im;
		end
		pending_volts.push_back(v);
	endtask

	task automatic pause_sender(int cycles);
		if (cycles > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (cycles - 1) @(negedge clk);
		end
	endtask

	task automatic drain;
		pause_sender(1);
		while (pending_volts.size() != 0) @(posedge clk);
		repeat (dcrs_pkg::LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_reg(dcrs_pkg::cfg_reg_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		case (idx)
			dcrs_pkg::REG_DC_LEVEL:     sh_dc = val[23:0];
			dcrs_pkg::REG_AC_AMPLITUDE: sh_amp = val[23:0];
			dcrs_pkg::REG_PHASE_STEP:   sh_step = val;
			dcrs_pkg::REG_PHASE_OFFSET: sh_offset = val;
			dcrs_pkg::REG_AC_DELAY:     sh_delay = val;
			dcrs_pkg::REG_DC_RISE_TIME: sh_rise = val;
			default:                    sh_ramp = val;
		endcase
	endtask

	task automatic write_all(logic [31:0] dc, logic [31:0] amp, logic [31:0] stp,
			logic [31:0] off, logic [31:0] dly, logic [31:0] rise, logic [31:0] rmp);
		write_reg(dcrs_pkg::REG_DC_LEVEL, dc);
		write_reg(dcrs_pkg::REG_AC_AMPLITUDE, amp);
		write_reg(dcrs_pkg::REG_PHASE_STEP, stp);
		write_reg(dcrs_pkg::REG_PHASE_OFFSET, off);
		write_reg(dcrs_pkg::REG_AC_DELAY, dly);
		write_reg(dcrs_pkg::REG_DC_RISE_TIME, rise);
		write_reg(dcrs_pkg::REG_AC_RAMP_TIME, rmp);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] pick_volt();
		case ($urandom_range(5))
			0: return 32'd0;
			1: return 32'h007f_ffff;
			2: return 32'hff80_0000;
			3: return $urandom_range(2000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_span();
		case ($urandom_range(5))
			0: return 32'd0;
			1: return 32'hffff_ffff;
			2: return $urandom;
			default: return $urandom_range(400);
		endcase
	endfunction

	function automatic logic [31:0] pick_time();
		logic [31:0] base;
		case ($urandom_range(7))
			0: return 32'd0;
			1: return 32'hffff_ffff;
			2: return $urandom;
			3: base = sh_delay;
			4: base = sh_rise;
			5: base = sh_ramp;
			default: return $urandom_range(600);
		endcase
		return base + $urandom_range(6) - 3;
	endfunction

	function automatic logic [31:0] pick_freq();
		case ($urandom_range(3))
			0: return 32'd0;
			1: return sh_step;
			default: return $urandom;
		endcase
	endfunction

	stim_row_t reset_rows[] = '{
		'{dcrs_pkg::MODE_TRAN, 32'd0, 32'd0, 1, 0, 0},
		'{dcrs_pkg::MODE_TRAN, 32'hffff_ffff, 32'hffff_ffff, 1, 0, 0},
		'{dcrs_pkg::MODE_DCOP, 32'd5, 32'd0, 1, 0, 0},
		'{dcrs_pkg::MODE_PHASOR, 32'd0, 32'd0, 1, 0, 0},
		'{dcrs_pkg::MODE_PHASOR, 32'd0, 32'h1234_5678, 1, 0, 0},
		'{MODE_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 1, 0, 0}
	};

	stim_row_t extreme_rows[] = '{
		'{dcrs_pkg::MODE_DCOP, 32'd0, 32'd0, 1, VMAX, 0},
		'{dcrs_pkg::MODE_TRAN, 32'd0, 32'd0, 1, VMAX, 0},
		'{dcrs_pkg::MODE_TRAN, 32'd10, 32'd0, 1, VMAX, 0},
		'{dcrs_pkg::MODE_PHASOR, 32'd0, 32'd0, 1, VMAX, 0},
		'{MODE_UNUSED, 32'd77, 32'd9, 1, 0, 0},
		'{dcrs_pkg::MODE_TRAN, 32'd11, 32'd0, 0, 0, 0},
		'{dcrs_pkg::MODE_TRAN, 32'd50, 32'd0, 0, 0, 0},
		'{dcrs_pkg::MODE_TRAN, 32'd99, 32'd0, 0, 0, 0},
		'{dcrs_pkg::MODE_TRAN, 32'd100, 32'd0, 0, 0, 0},
		'{dcrs_pkg::MODE_TRAN, 32'hffff_ffff, 32'd0, 0, 0, 0},
		'{dcrs_pkg::MODE_PHASOR, 32'd0, 32'd1000, 0, 0, 0},
		'{dcrs_pkg::MODE_PHASOR, 32'd0, 32'd1001, 1, 0, 0},
		'{dcrs_pkg::MODE_PHASOR, 32'd0, 32'hffff_ffff, 1, 0, 0}
	};

	stim_row_t rise_rows[] = '{
		'{dcrs_pkg::MODE_DCOP, 32'd0, 32'd0, 1, 0, 0},
		'{dcrs_pkg::MODE_TRAN, 32'd0, 32'd0, 1, 0, 0},
		'{dcrs_pkg::MODE_TRAN, 32'd1, 32'd0, 0, 0, 0},
		'{dcrs_pkg::MODE_TRAN, 32'h7fff_ffff, 32'd0, 0, 0, 0},
		'{dcrs_pkg::MODE_TRAN, 32'hffff_fffe, 32'd0, 0, 0, 0},
		'{dcrs_pkg::MODE_PHASOR, 32'd0, 32'd3, 0, 0, 0}
	};

	initial begin
		int n_items, burst;
		bit gaps;
		start = 0;
		mode = dcrs_pkg::MODE_TRAN;
		time_tick = '0;
		analysis_step = '0;
		cfg_we = 0;
		cfg_idx = dcrs_pkg::REG_DC_LEVEL;
		cfg_data = '0;
		{sh_dc, sh_amp} = '0;
		{sh_step, sh_offset, sh_delay, sh_rise, sh_ramp} = '0;
		arst_n = 0;
		repeat (8) @(negedge clk);
		arst_n = 1;

		foreach (reset_rows[i])
			send_item(reset_rows[i].mode, reset_rows[i].t, reset_rows[i].fa, 1,
				reset_rows[i].re, reset_rows[i].im);
		drain();
		write_all(32'h007f_ffff, 32'hff80_0000, 32'd1000, 32'd0, 32'd10, 32'd0, 32'd100);
		foreach (extreme_rows[i])
			send_item(extreme_rows[i].mode, extreme_rows[i].t, extreme_rows[i].fa,
				extreme_rows[i].typed, extreme_rows[i].re, extreme_rows[i].im);
		drain();
		write_all(32'hff80_0000, 32'h007f_ffff, 32'd0, 32'hffff_ffff, 32'hffff_ffff,
			32'hffff_ffff, 32'hffff_ffff);
		foreach (rise_rows[i])
			send_item(rise_rows[i].mode, rise_rows[i].t, rise_rows[i].fa,
				rise_rows[i].typed, rise_rows[i].re, rise_rows[i].im);
		drain();

		n_items = 0;
		burst = 0;
		while (n_items < 1120) begin
			write_all(pick_volt(), pick_volt(), pick_span(), pick_span(), pick_span(),
				pick_span(), pick_span());
			gaps = $urandom_range(3) != 0;
			for (int k = 0; k < 80; k++) begin
				send_item(2'($urandom_range(3)), pick_time(), pick_freq());
				n_items++;
				if (k == 40 && n_items < 200) begin
					// hold until the pipeline has emptied
					pause_sender(1);
					while (pending_volts.size() != 0) @(posedge clk);
				end else if (gaps && --burst <= 0) begin
					burst = $urandom_range(12, 1);
					pause_sender($urandom_range(6));
				end
			end
			drain();
		end

		if (errors == 0 && pending_volts.size() == 0)
			$display("dc_ramp_sine_source_eval_tb OK");
		else
			$display("dc_ramp_sine_source_eval_tb NOT OK");
		$finish;
	end

endmodule

FILE: sim.f
sv/dcrs_pkg.sv
sv/dcrs_div.sv
sv/dcrs_sin.sv
sv/dc_ramp_sine_source_eval.sv
dv/dc_ramp_sine_source_eval_tb.sv
